/* rtl/core/awt_pkg.sv */
package awt_pkg;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [7:0] OFF_CR   = 8'h00;
  localparam logic [7:0] OFF_TORR = 8'h04;
  localparam logic [7:0] OFF_CCVR = 8'h08;
  localparam logic [7:0] OFF_CRR  = 8'h0c;
  localparam logic [7:0] OFF_STAT = 8'h10;
  localparam logic [7:0] OFF_EOI  = 8'h14;

  localparam logic [7:0] KICK_CODE = 8'h76;
  localparam int         CR_EN_BIT   = 0;
  localparam int         CR_RMOD_BIT = 1;
  localparam logic [4:0] TOP_BASE  = 5'd16;
  localparam int         PULSE_W   = 9;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  reg_offset;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        interrupt_out;
    logic        system_reset;
  } out_item_t;

endpackage

/* rtl/core/apb_watchdog_timer_top.sv */
// Watchdog timer with a small register file, driven by a stream of requests.
// Input channel (in_valid/in_ready/in_data): each request is a register read,
// a register write, one timer tick or a no-op (in_data.command). Output channel
// (out_valid/out_ready/out_data): exactly one result per request, in order,
// carrying read data, the pending interrupt and the reset pulse level as they
// stand after that request.
// Flow: an accepted request sits in the input register, is processed there,
// and its result is captured in the result register once that can advance.
// Throughput: one request per cycle while out_ready stays high; the counter update,
// register decode and reload mask all sit between input and result registers.
// Reset (rst_n low, synchronous): both channels empty, watchdog disabled,
// counter at 0xFFFF, interrupt and reset pulse cleared.
// Stall: while out_ready is low the result register holds; the request in the
// input register waits there and in_ready drops once both stages are full.
// Timer state advances only on tick requests, so stalls never lose ticks.
module apb_watchdog_timer_top #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  awt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output awt_pkg::out_item_t out_data
);

  logic               req_valid_r;
  awt_pkg::in_item_t  req_r;
  logic               res_valid_r;
  awt_pkg::out_item_t res_r;
  awt_pkg::out_item_t core_result;
  logic               advance;
  logic               proc_fire;

  assign advance   = !res_valid_r || out_ready;
  assign proc_fire = req_valid_r && advance;
  assign in_ready  = !req_valid_r || advance;

  awt_core #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .proc_valid (proc_fire),
    .proc_item  (req_r),
    .proc_result(core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (in_ready) req_valid_r <= in_valid;
      if (advance) res_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) req_r <= in_data;
    if (proc_fire) res_r <= core_result;
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

endmodule

/* rtl/core/awt_core.sv */
module awt_core #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              proc_valid,
  input  awt_pkg::in_item_t proc_item,
  output awt_pkg::out_item_t proc_result
);

  logic                         enable_r, enable_nxt;
  logic                         irq_mode_r, irq_mode_nxt;
  logic [2:0]                   rpl_r, rpl_nxt;
  logic [7:0]                   torr_r, torr_nxt;
  logic [COUNTER_WIDTH-1:0]     counter_r, counter_nxt;
  logic                         irq_r, irq_nxt;
  logic [awt_pkg::PULSE_W-1:0]  pulse_r, pulse_nxt;

  logic [4:0]                   reload_exp;
  logic [COUNTER_WIDTH-1:0]     reload_val;
  logic [awt_pkg::PULSE_W-1:0]  pulse_start;
  logic [awt_pkg::PULSE_W-1:0]  pulse_dec;
  logic [31:0]                  rd_data;

  // reload = 2^(16+top)-1, saturating to all ones of the counter width
  always_comb begin
    reload_exp = awt_pkg::TOP_BASE + {1'b0, torr_r[3:0]};
    for (int i = 0; i < COUNTER_WIDTH; i++) begin
      reload_val[i] = (5'(i) < reload_exp);
    end
  end

  assign pulse_start = awt_pkg::PULSE_W'(1) << ({1'b0, rpl_r} + 4'd1);
  assign pulse_dec   = (pulse_r != '0) ? (pulse_r - awt_pkg::PULSE_W'(1)) : pulse_r;

  always_comb begin
    enable_nxt   = enable_r;
    irq_mode_nxt = irq_mode_r;
    rpl_nxt      = rpl_r;
    torr_nxt     = torr_r;
    counter_nxt  = counter_r;
    irq_nxt      = irq_r;
    pulse_nxt    = pulse_r;
    rd_data      = '0;
    if (proc_valid) begin
      case (proc_item.command)
        awt_pkg::CMD_READ: begin
          case (proc_item.reg_offset)
            awt_pkg::OFF_CR:   rd_data = {27'd0, rpl_r, irq_mode_r, enable_r};
            awt_pkg::OFF_TORR: rd_data = {24'd0, torr_r};
            awt_pkg::OFF_CCVR: rd_data = 32'(counter_r);
            awt_pkg::OFF_STAT: rd_data = {31'd0, irq_r};
            awt_pkg::OFF_EOI:  irq_nxt = 1'b0;
            default: ;
          endcase
        end
        awt_pkg::CMD_WRITE: begin
          case (proc_item.reg_offset)
            awt_pkg::OFF_CR: begin
              enable_nxt   = proc_item.write_data[awt_pkg::CR_EN_BIT];
              irq_mode_nxt = proc_item.write_data[awt_pkg::CR_RMOD_BIT];
              rpl_nxt      = proc_item.write_data[4:2];
              if (enable_nxt && !enable_r) counter_nxt = reload_val;
            end
            awt_pkg::OFF_TORR: torr_nxt = proc_item.write_data[7:0];
            awt_pkg::OFF_CRR: begin
              if (proc_item.write_data[7:0] == awt_pkg::KICK_CODE) begin
                counter_nxt = reload_val;
                irq_nxt     = 1'b0;
              end
            end
            default: ;
          endcase
        end
        awt_pkg::CMD_TICK: begin
          pulse_nxt = pulse_dec;
          if (enable_r) begin
            if (counter_r == '0) begin
              counter_nxt = reload_val;
              // expiry in reset mode or with irq pending starts a reset pulse
              if (irq_mode_r && !irq_r) irq_nxt = 1'b1;
              else pulse_nxt = pulse_start;
            end else begin
              counter_nxt = counter_r - COUNTER_WIDTH'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign proc_result.read_data     = rd_data;
  assign proc_result.interrupt_out = irq_nxt;
  assign proc_result.system_reset  = (pulse_nxt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      irq_mode_r <= 1'b0;
      rpl_r      <= '0;
      torr_r     <= '0;
      counter_r  <= COUNTER_WIDTH'(32'hFFFF);
      irq_r      <= 1'b0;
      pulse_r    <= '0;
    end else begin
      enable_r   <= enable_nxt;
      irq_mode_r <= irq_mode_nxt;
      rpl_r      <= rpl_nxt;
      torr_r     <= torr_nxt;
      counter_r  <= counter_nxt;
      irq_r      <= irq_nxt;
      pulse_r    <= pulse_nxt;
    end
  end

`ifndef SYNTHESIS
  a_disabled_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
    proc_valid && proc_item.command == awt_pkg::CMD_TICK && !enable_r
    |=> $stable(counter_r))
    else $error("counter moved on a tick while disabled");

  a_irq_rises_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(irq_r) |-> $past(proc_valid && proc_item.command == awt_pkg::CMD_TICK))
    else $error("interrupt raised outside a tick");

  a_pulse_shape: assert property (@(posedge clk) disable iff (!rst_n)
    proc_valid && proc_item.command == awt_pkg::CMD_TICK
    |=> (pulse_r == '0) || $onehot(pulse_r)
        || (pulse_r == $past(pulse_r) - awt_pkg::PULSE_W'(1)))
    else $error("reset pulse counter jumped to an invalid value");

  a_pulse_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    proc_valid && proc_item.command != awt_pkg::CMD_TICK |=> $stable(pulse_r))
    else $error("reset pulse changed on a register access");
`endif

endmodule

/* verif/awt_checker.sv */
module awt_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  awt_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  awt_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted watchdog state
  logic                         wd_en;
  logic                         wd_imode;
  logic [2:0]                   wd_rpl;
  logic [7:0]                   wd_torr;
  logic [31:0]                  wd_cnt;
  logic                         wd_irq;
  logic [awt_pkg::PULSE_W-1:0]  wd_pulse;

  awt_pkg::out_item_t due_results[$];

  function automatic logic [31:0] reload_val(input logic [7:0] torr);
    int unsigned e;
    e = awt_pkg::TOP_BASE + torr[3:0];
    if (e >= 32) return '1;
    return (32'd1 << e) - 32'd1;
  endfunction

  task automatic watchdog_step(input awt_pkg::in_item_t r, output awt_pkg::out_item_t res);
    logic [31:0] rd;
    rd = '0;
    case (r.command)
      awt_pkg::CMD_READ: begin
        case (r.reg_offset)
          awt_pkg::OFF_CR:   rd = {27'd0, wd_rpl, wd_imode, wd_en};
          awt_pkg::OFF_TORR: rd = {24'd0, wd_torr};
          awt_pkg::OFF_CCVR: rd = wd_cnt;
          awt_pkg::OFF_STAT: rd = {31'd0, wd_irq};
          awt_pkg::OFF_EOI:  wd_irq = 1'b0;
          default:  ;
        endcase
      end
      awt_pkg::CMD_WRITE: begin
        case (r.reg_offset)
          awt_pkg::OFF_CR: begin
            // only a 0->1 transition of enable reloads
            if (r.write_data[awt_pkg::CR_EN_BIT] && !wd_en) wd_cnt = reload_val(wd_torr);
            wd_en    = r.write_data[awt_pkg::CR_EN_BIT];
            wd_imode = r.write_data[awt_pkg::CR_RMOD_BIT];
            wd_rpl   = r.write_data[4:2];
          end
          awt_pkg::OFF_TORR: wd_torr = r.write_data[7:0];
          awt_pkg::OFF_CRR: begin
            if (r.write_data[7:0] == awt_pkg::KICK_CODE) begin
              wd_cnt = reload_val(wd_torr);
              wd_irq = 1'b0;
            end
          end
          default: ;
        endcase
      end
      awt_pkg::CMD_TICK: begin
        if (wd_pulse != 0) wd_pulse = wd_pulse - awt_pkg::PULSE_W'(1);
        if (wd_en) begin
          if (wd_cnt == 0) begin
            wd_cnt = reload_val(wd_torr);
            // expiry in reset mode or with irq pending starts a reset pulse
            if (wd_imode && !wd_irq) wd_irq = 1'b1;
            else wd_pulse = awt_pkg::PULSE_W'(1) << (wd_rpl + 4'd1);
          end else begin
            wd_cnt = wd_cnt - 32'd1;
          end
        end
      end
      default: ;
    endcase
    res.read_data     = rd;
    res.interrupt_out = wd_irq;
    res.system_reset  = (wd_pulse != 0);
  endtask

  always @(posedge clk) begin : track
    awt_pkg::out_item_t want;
    int                 errs;
    if (!rst_n) begin
      wd_en    = 1'b0;
      wd_imode = 1'b0;
      wd_rpl   = '0;
      wd_torr  = '0;
      wd_cnt   = 32'h0000_FFFF;
      wd_irq   = 1'b0;
      wd_pulse = '0;
      due_results.delete();
      fail_count  <= 0;
      pending_cnt <= 0;
    end else begin
      errs = 0;
      // retire the result first so a stray one never matches this edge's request
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result with no request outstanding: %0h", out_data);
          errs++;
        end else begin
          want = due_results.pop_front();
          if (out_data.read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, out_data.read_data);
            errs++;
          end
          if (out_data.interrupt_out !== want.interrupt_out) begin
            $error("interrupt_out: expected %0b, got %0b", want.interrupt_out,
                   out_data.interrupt_out);
            errs++;
          end
          if (out_data.system_reset !== want.system_reset) begin
            $error("system_reset: expected %0b, got %0b", want.system_reset,
                   out_data.system_reset);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        watchdog_step(in_data, want);
        due_results.push_back(want);
      end
      fail_count  <= fail_count + errs;
      pending_cnt <= due_results.size();
    end
  end

endmodule

/* verif/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int WD_LIMIT = 3000;
  localparam int HOLD_CYCLES = 64;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  awt_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  awt_pkg::out_item_t out_data;
  int                 fail_count;
  int                 pending_cnt;

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        long_hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  always #4 clk = ~clk;

  apb_watchdog_timer_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  awt_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending_cnt(pending_cnt)
  );

  // result side: random stalls plus one long hold-off to back up the pipe
  always @(posedge clk) begin
    if (long_hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WD_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idling(input idle_mode_e m);
    case (m)
      IDLE_NONE: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin sender_idle_pct = 56; recv_stall_pct = 0;  end
      IDLE_RECV: begin sender_idle_pct = 0;  recv_stall_pct = 56; end
      default:   begin sender_idle_pct = 14; recv_stall_pct = 14; end
    endcase
  endtask

  task automatic send_req(input logic [1:0] cmd, input logic [7:0] off,
                          input logic [31:0] wdata);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, reg_offset: off, write_data: wdata};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_ticks(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_req(awt_pkg::CMD_TICK, 8'($urandom()), $urandom());
  endtask

  // ticks with status reads and varying idling
  task automatic tick_window(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 64 == 0) set_idling(idle_mode_e'($urandom_range(3)));
      send_req(awt_pkg::CMD_TICK, 8'($urandom()), $urandom());
      if ($urandom_range(3) == 0)
        send_req(awt_pkg::CMD_READ,
                 ($urandom_range(1) ? awt_pkg::OFF_CCVR : awt_pkg::OFF_STAT), $urandom());
    end
    set_idling(IDLE_NONE);
  endtask

  function automatic logic [7:0] any_reg();
    case ($urandom_range(5))
      0:       return awt_pkg::OFF_CR;
      1:       return awt_pkg::OFF_TORR;
      2:       return awt_pkg::OFF_CCVR;
      3:       return awt_pkg::OFF_CRR;
      4:       return awt_pkg::OFF_STAT;
      default: return awt_pkg::OFF_EOI;
    endcase
  endfunction

  task automatic random_req();
    logic [7:0]  off;
    logic [31:0] d;
    int unsigned pick;
    pick = $urandom_range(99);
    off  = ($urandom_range(4) == 0) ? 8'($urandom()) : any_reg();
    d    = $urandom();
    if (pick < 35) begin
      send_req(awt_pkg::CMD_TICK, off, d);
    end else if (pick < 60) begin
      send_req(awt_pkg::CMD_READ, off, d);
    end else if (pick < 90) begin
      // kicks mostly carry the right key with junk in the upper bits
      if (off == awt_pkg::OFF_CRR && $urandom_range(2) != 0)
        d = (d & 32'hFFFF_FF00) | awt_pkg::KICK_CODE;
      send_req(awt_pkg::CMD_WRITE, off, d);
    end else if (pick < 95) begin
      send_req(CMD_NOP, off, d);
    end else begin
      send_req(2'($urandom()), 8'($urandom()), d);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    set_idling(IDLE_NONE);

    // reset values, unmapped and unaligned offsets, idle command, a tick while disabled
    send_req(awt_pkg::CMD_READ, awt_pkg::OFF_CR, 32'h0);
    send_req(awt_pkg::CMD_READ, awt_pkg::OFF_TORR, 32'h0);
    send_req(awt_pkg::CMD_READ, awt_pkg::OFF_CCVR, 32'h0);
    send_req(awt_pkg::CMD_READ, awt_pkg::OFF_CRR, 32'h0);
    send_req(awt_pkg::CMD_READ, awt_pkg::OFF_STAT, 32'h0);
    send_req(awt_pkg::CMD_READ, awt_pkg::OFF_EOI, 32'h0);
    send_req(awt_pkg::CMD_READ, 8'h02, 32'h0);
    send_req(awt_pkg::CMD_READ, 8'hFF, 32'hFFFF_FFFF);
    send_req(CMD_NOP, awt_pkg::OFF_CR, 32'hFFFF_FFFF);
    send_req(awt_pkg::CMD_TICK, 8'h00, 32'h0);
    // read-only registers ignore writes
    send_req(awt_pkg::CMD_WRITE, awt_pkg::OFF_CCVR, 32'hFFFF_FFFF);
    send_req(awt_pkg::CMD_WRITE, awt_pkg::OFF_STAT, 32'hFFFF_FFFF);
    send_req(awt_pkg::CMD_WRITE, awt_pkg::OFF_EOI, 32'hFFFF_FFFF);
    // largest timeout, everything set in the control register
    send_req(awt_pkg::CMD_WRITE, awt_pkg::OFF_TORR, 32'hFFFF_FFFF);
    send_req(awt_pkg::CMD_READ, awt_pkg::OFF_TORR, 32'h0);
    send_req(awt_pkg::CMD_WRITE, awt_pkg::OFF_CR, 32'hFFFF_FFFF);
    send_req(awt_pkg::CMD_READ, awt_pkg::OFF_CR, 32'h0);
    send_req(awt_pkg::CMD_TICK, 8'hFF, 32'hFFFF_FFFF);
    send_req(awt_pkg::CMD_READ, awt_pkg::OFF_CCVR, 32'h0);
    // wrong key is ignored, right key with upper bits set still kicks
    send_req(awt_pkg::CMD_WRITE, awt_pkg::OFF_CRR, 32'h0000_0075);
    send_req(awt_pkg::CMD_WRITE, awt_pkg::OFF_CRR, 32'hFFFF_FF76);
    send_req(awt_pkg::CMD_READ, awt_pkg::OFF_CCVR, 32'h0);
    send_req(awt_pkg::CMD_WRITE, awt_pkg::OFF_CR, 32'h0);
    send_req(awt_pkg::CMD_WRITE, awt_pkg::OFF_TORR, 32'h0);
    send_req(awt_pkg::CMD_WRITE, awt_pkg::OFF_CRR, 32'h0000_0076);
    send_req(awt_pkg::CMD_READ, awt_pkg::OFF_CCVR, 32'h0);

    // reset mode, longest pulse; upper timeout bits stored, counter runs down
    send_req(awt_pkg::CMD_WRITE, awt_pkg::OFF_TORR, 32'h0000_00F0);
    send_req(awt_pkg::CMD_WRITE, awt_pkg::OFF_CR, 32'h0000_001D);
    send_ticks(20);
    tick_window(40);

    // interrupt mode, shortest pulse
    send_req(awt_pkg::CMD_WRITE, awt_pkg::OFF_CR, 32'h0);
    send_req(awt_pkg::CMD_WRITE, awt_pkg::OFF_CR, 32'h0000_0003);
    tick_window(60);
    send_req(awt_pkg::CMD_READ, awt_pkg::OFF_EOI, 32'h0);
    send_req(awt_pkg::CMD_READ, awt_pkg::OFF_STAT, 32'h0);
    tick_window(40);
    send_req(awt_pkg::CMD_WRITE, awt_pkg::OFF_CRR, 32'h0000_0076);
    send_req(awt_pkg::CMD_READ, awt_pkg::OFF_STAT, 32'h0);

    for (int ph = 0; ph < 4; ph++) begin
      set_idling(idle_mode_e'(ph));
      if (ph == IDLE_NONE) long_hold_req <= 1'b1;
      for (int i = 0; i < 120; i++) random_req();
    end

    set_idling(IDLE_NONE);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
